// File: rtl/pma_pkg.sv
// Shared types, constants and the modular shift-and-add step of the arithmetic unit.
package pma_pkg;

    // Width of a stored residue; it covers every modulus below 2**31.
    localparam int RW = 32;

    // Operation codes of an input item.
    typedef enum logic [2:0] {
        OP_REDUCE  = 3'd0,
        OP_ADD     = 3'd1,
        OP_SUB     = 3'd2,
        OP_MUL     = 3'd3,
        OP_NEG     = 3'd4,
        OP_INVERSE = 3'd5,
        OP_DIVIDE  = 3'd6,
        OP_POWER   = 3'd7
    } op_t;

    // Control of the serial multiply-accumulate unit for one cycle.
    typedef struct packed {
        logic step;
        logic first;
        logic din;
    } pma_ctl_t;

    // One step of an MSB-first modular product: (2*acc + din*add) mod m,
    // where acc and add are already below m.
    function automatic logic [RW-1:0] mod_step(input logic [RW-1:0] acc,
                                               input logic [RW-1:0] add,
                                               input logic din,
                                               input logic [RW:0] m);
        logic [RW:0] dbl;
        logic [RW:0] sum;
        begin
            dbl = {acc, 1'b0};
            if (dbl >= m)
            begin
                dbl = dbl - m;
            end
            sum = dbl + (din ? {1'b0, add} : '0);
            if (sum >= m)
            begin
                sum = sum - m;
            end
            return sum[RW-1:0];
        end
    endfunction

endpackage

// File: rtl/pma_channels.sv
// Handshake channels for the input items and the result items.
interface pma_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  op;
    logic [29:0] left;
    logic [29:0] right;
    logic signed [63:0] wide_value;
    logic [62:0] exponent;

    modport source (output valid, op, left, right, wide_value, exponent, input ready);
    modport sink (input valid, op, left, right, wide_value, exponent, output ready);
endinterface

interface pma_out_if;
    logic        valid;
    logic        ready;
    logic [29:0] result;
    logic        error;

    modport source (output valid, result, error, input ready);
    modport sink (input valid, result, error, output ready);
endinterface

// File: rtl/pma_serial_mac.sv
// Serial modular multiply-accumulate unit with two accumulators sharing one bit stream.
module pma_serial_mac
    import pma_pkg::*;
#(
    parameter int unsigned MODULUS = 1000000007
)
(
    input  logic          clk,
    input  pma_ctl_t      ctl,
    input  logic [RW-1:0] add0,
    input  logic [RW-1:0] add1,
    output logic [RW-1:0] acc0,
    output logic [RW-1:0] acc1
);

    localparam logic [RW:0] MOD_W = (RW+1)'(MODULUS);

    logic [RW-1:0] acc0_reg;
    logic [RW-1:0] acc1_reg;
    logic [RW-1:0] base0;
    logic [RW-1:0] base1;

    // On the first step of a pass the accumulators count as zero.
    assign base0 = ctl.first ? '0 : acc0_reg;
    assign base1 = ctl.first ? '0 : acc1_reg;

    // Both accumulators take the same multiplier bit each cycle in which ctl.step is set.
    always_ff @(posedge clk)
    begin
        if (ctl.step)
        begin
            acc0_reg <= mod_step(base0, add0, ctl.din, MOD_W);
            acc1_reg <= mod_step(base1, add1, ctl.din, MOD_W);
        end
    end

    assign acc0 = acc0_reg;
    assign acc1 = acc1_reg;

endmodule

// File: rtl/prime_modular_alu.sv
// Top level of the modular arithmetic unit: control sequencer and result register.
// Reduce takes one 64-bit pass; other ops reduce both operands, then mul adds a product
// pass, inverse one per Euclid step, divide those and a product, power one per exponent bit.
// Throughput: one item at a time; every pass goes through the one serial multiply unit,
// which takes one multiplier bit per cycle over 32 or 64 bits.
// A new item is taken while an earlier result still waits in the output register.
// Reset (rst_n, asynchronous, active low) returns the sequencer to idle and empties the output.
module prime_modular_alu
    import pma_pkg::*;
#(
    parameter int unsigned MODULUS = 1000000007
)
(
    input  logic      clk,
    input  logic      rst_n,
    pma_in_if.sink    in_ch,
    pma_out_if.source out_ch
);

    localparam logic [RW:0] MOD_W = (RW+1)'(MODULUS);

    typedef enum logic [10:0] {
        S_IDLE = 11'b00000000001,
        S_RA   = 11'b00000000010,
        S_RB   = 11'b00000000100,
        S_RW   = 11'b00000001000,
        S_MUL  = 11'b00000010000,
        S_EDIV = 11'b00000100000,
        S_PSQ  = 11'b00001000000,
        S_POST = 11'b00010000000,
        S_ECHK = 11'b00100000000,
        S_PCHK = 11'b01000000000,
        S_DONE = 11'b10000000000
    } state_t;

    state_t        state_reg, state_next;
    state_t        prev_reg, prev_next;
    op_t           op_reg, op_next;
    logic [29:0]   right_raw_reg, right_raw_next;
    logic          neg_reg, neg_next;
    logic [63:0]   sh_reg, sh_next;
    logic [6:0]    cnt_reg, cnt_next;
    logic          first_reg, first_next;
    logic [62:0]   e_reg, e_next;
    logic [RW-1:0] a_reg, a_next;
    logic [RW-1:0] r0_reg, r0_next;
    logic [RW-1:0] r1_reg, r1_next;
    logic [RW-1:0] s0_reg, s0_next;
    logic [RW-1:0] s1_reg, s1_next;
    logic [RW-1:0] rem_reg, rem_next;
    logic [RW-1:0] res_reg, res_next;
    logic          err_reg, err_next;
    logic          ov_reg, ov_next;
    logic [29:0]   ores_reg, ores_next;
    logic          oerr_reg, oerr_next;

    pma_ctl_t      ctl;
    logic [RW-1:0] add0;
    logic [RW-1:0] add1;
    logic [RW-1:0] acc0;
    logic [RW-1:0] acc1;

    logic          in_xfer;
    logic          out_xfer;
    logic          stepping;
    logic [RW-1:0] rem_cur;
    logic [RW-1:0] rem_shift;
    logic          qbit;
    logic [RW:0]   sum_ab;
    logic [RW:0]   wide_tmp;
    logic [63:0]   mag;

    assign in_xfer  = in_ch.valid && in_ch.ready;
    assign out_xfer = out_ch.valid && out_ch.ready;
    assign stepping = (state_reg == S_RA) || (state_reg == S_RB) || (state_reg == S_RW) ||
                      (state_reg == S_MUL) || (state_reg == S_EDIV) || (state_reg == S_PSQ);

    // Restoring division of r0 by r1, one quotient bit per cycle.
    assign rem_cur   = first_reg ? '0 : rem_reg;
    assign rem_shift = {rem_cur[RW-2:0], sh_reg[63]};
    assign qbit      = (rem_shift >= r1_reg);

    // Serial unit control and addends for each pass.
    always_comb
    begin
        ctl.step  = stepping;
        ctl.first = first_reg;
        ctl.din   = (state_reg == S_EDIV) ? qbit : sh_reg[63];
        add1      = '0;
        case (state_reg)
            S_MUL:   add0 = a_reg;
            S_EDIV:  add0 = s1_reg;
            S_PSQ:
            begin
                add0 = r0_reg;
                add1 = r1_reg;
            end
            default: add0 = RW'(1);
        endcase
    end

    pma_serial_mac #(.MODULUS(MODULUS)) u_mac (
        .clk  (clk),
        .ctl  (ctl),
        .add0 (add0),
        .add1 (add1),
        .acc0 (acc0),
        .acc1 (acc1)
    );

    assign mag = ~in_ch.wide_value + 64'd1;

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        prev_next      = prev_reg;
        op_next        = op_reg;
        right_raw_next = right_raw_reg;
        neg_next       = neg_reg;
        sh_next        = sh_reg;
        cnt_next       = cnt_reg;
        first_next     = first_reg;
        e_next         = e_reg;
        a_next         = a_reg;
        r0_next        = r0_reg;
        r1_next        = r1_reg;
        s0_next        = s0_reg;
        s1_next        = s1_reg;
        rem_next       = rem_reg;
        res_next       = res_reg;
        err_next       = err_reg;
        ov_next        = ov_reg && !out_xfer;
        ores_next      = ores_reg;
        oerr_next      = oerr_reg;
        sum_ab         = '0;
        wide_tmp       = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    op_next        = op_t'(in_ch.op);
                    right_raw_next = in_ch.right;
                    e_next         = in_ch.exponent;
                    err_next       = 1'b0;
                    first_next     = 1'b1;
                    if (op_t'(in_ch.op) == OP_REDUCE)
                    begin
                        neg_next   = in_ch.wide_value[63];
                        sh_next    = in_ch.wide_value[63] ? mag : in_ch.wide_value;
                        cnt_next   = 7'd64;
                        state_next = S_RW;
                    end
                    else
                    begin
                        sh_next    = {2'b00, in_ch.left, 32'd0};
                        cnt_next   = 7'd32;
                        state_next = S_RA;
                    end
                end
            end

            S_RA, S_RB, S_RW, S_MUL, S_EDIV, S_PSQ:
            begin
                sh_next    = {sh_reg[62:0], 1'b0};
                cnt_next   = cnt_reg - 7'd1;
                first_next = 1'b0;
                if (state_reg == S_EDIV)
                begin
                    rem_next = qbit ? rem_shift - r1_reg : rem_shift;
                end
                if (cnt_reg == 7'd1)
                begin
                    prev_next  = state_reg;
                    state_next = S_POST;
                end
            end

            S_POST:
            begin
                first_next = 1'b1;
                cnt_next   = 7'd32;
                case (prev_reg)
                    S_RA:
                    begin
                        a_next     = acc0;
                        sh_next    = {2'b00, right_raw_reg, 32'd0};
                        state_next = S_RB;
                    end
                    S_RB:
                    begin
                        state_next = S_DONE;
                        case (op_reg)
                            OP_ADD:
                            begin
                                sum_ab   = {1'b0, a_reg} + {1'b0, acc0};
                                wide_tmp = (sum_ab >= MOD_W) ? sum_ab - MOD_W : sum_ab;
                                res_next = wide_tmp[RW-1:0];
                            end
                            OP_SUB:
                            begin
                                sum_ab   = {1'b0, a_reg} + MOD_W - {1'b0, acc0};
                                wide_tmp = (a_reg >= acc0) ? {1'b0, a_reg - acc0} : sum_ab;
                                res_next = wide_tmp[RW-1:0];
                            end
                            OP_NEG:
                            begin
                                wide_tmp = MOD_W - {1'b0, a_reg};
                                res_next = (a_reg == '0) ? '0 : wide_tmp[RW-1:0];
                            end
                            OP_MUL:
                            begin
                                sh_next    = {acc0, 32'd0};
                                state_next = S_MUL;
                            end
                            OP_INVERSE, OP_DIVIDE:
                            begin
                                r0_next    = MOD_W[RW-1:0];
                                r1_next    = (op_reg == OP_INVERSE) ? a_reg : acc0;
                                s0_next    = '0;
                                s1_next    = RW'(1);
                                state_next = S_ECHK;
                            end
                            OP_POWER:
                            begin
                                r0_next    = RW'(1);
                                r1_next    = a_reg;
                                state_next = S_PCHK;
                            end
                            default:
                            begin
                                res_next = '0;
                            end
                        endcase
                    end
                    S_RW:
                    begin
                        wide_tmp   = MOD_W - {1'b0, acc0};
                        res_next   = (neg_reg && acc0 != '0) ? wide_tmp[RW-1:0] : acc0;
                        state_next = S_DONE;
                    end
                    S_MUL:
                    begin
                        res_next   = acc0;
                        state_next = S_DONE;
                    end
                    S_EDIV:
                    begin
                        r0_next    = r1_reg;
                        r1_next    = rem_reg;
                        s0_next    = s1_reg;
                        sum_ab     = {1'b0, s0_reg} + MOD_W - {1'b0, acc0};
                        wide_tmp   = (s0_reg >= acc0) ? {1'b0, s0_reg - acc0} : sum_ab;
                        s1_next    = wide_tmp[RW-1:0];
                        state_next = S_ECHK;
                    end
                    S_PSQ:
                    begin
                        if (e_reg[0])
                        begin
                            r0_next = acc0;
                        end
                        r1_next    = acc1;
                        e_next     = {1'b0, e_reg[62:1]};
                        state_next = S_PCHK;
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end

            // One Euclid step per visit until the remainder reaches zero; then a gcd other than one is an error.
            S_ECHK:
            begin
                first_next = 1'b1;
                cnt_next   = 7'd32;
                if (r1_reg == '0)
                begin
                    if (r0_reg != RW'(1))
                    begin
                        err_next   = 1'b1;
                        res_next   = '0;
                        state_next = S_DONE;
                    end
                    else if (op_reg == OP_INVERSE)
                    begin
                        res_next   = s0_reg;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        sh_next    = {s0_reg, 32'd0};
                        state_next = S_MUL;
                    end
                end
                else
                begin
                    sh_next    = {r0_reg, 32'd0};
                    state_next = S_EDIV;
                end
            end

            // Square and multiply, lowest exponent bit first.
            S_PCHK:
            begin
                first_next = 1'b1;
                cnt_next   = 7'd32;
                if (e_reg == '0)
                begin
                    res_next   = r0_reg;
                    state_next = S_DONE;
                end
                else
                begin
                    sh_next    = {r1_reg, 32'd0};
                    state_next = S_PSQ;
                end
            end

            // Hand the result to the output register once it is free or its old result is being taken.
            S_DONE:
            begin
                if (!ov_reg || out_ch.ready)
                begin
                    ov_next    = 1'b1;
                    ores_next  = res_reg[29:0];
                    oerr_next  = err_reg;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            prev_reg  <= S_IDLE;
            ov_reg    <= 1'b0;
            cnt_reg   <= '0;
            first_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            prev_reg  <= prev_next;
            ov_reg    <= ov_next;
            cnt_reg   <= cnt_next;
            first_reg <= first_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        right_raw_reg <= right_raw_next;
        neg_reg       <= neg_next;
        sh_reg        <= sh_next;
        e_reg         <= e_next;
        a_reg         <= a_next;
        r0_reg        <= r0_next;
        r1_reg        <= r1_next;
        s0_reg        <= s0_next;
        s1_reg        <= s1_next;
        rem_reg       <= rem_next;
        res_reg       <= res_next;
        err_reg       <= err_next;
        ores_reg      <= ores_next;
        oerr_reg      <= oerr_next;
    end

    assign in_ch.ready   = (state_reg == S_IDLE);
    assign out_ch.valid  = ov_reg;
    assign out_ch.result = ores_reg;
    assign out_ch.error  = oerr_reg;

endmodule

// File: rtl/pma_checker.sv
// Port-level checks of the modular arithmetic unit and their attachment to the top level.
module pma_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [29:0] out_result,
    input logic        out_error
);

    // A waiting result stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_result) && $stable(out_error))
        else $error("result changed or vanished while stalled");

    // Only one item is in work at a time.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second item taken while one is in work");

    // A failed inverse or divide returns zero.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_error |-> out_result == '0)
        else $error("non-zero result with error flag");

endmodule

bind prime_modular_alu pma_checker u_pma_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_result (out_ch.result),
    .out_error  (out_ch.error)
);
